/* sv/ris_pkg.sv */
// Package: shared types and constants of the refuel interlock sequencer.
`default_nettype none
package ris_pkg;
	localparam int LogDepth = 12;
	localparam int LogAw = $clog2(LogDepth);
	localparam int LogCw = $clog2(LogDepth + 1);

	typedef enum logic [3:0] {
		ST_IDLE = 4'd0, ST_APPROACH = 4'd1, ST_ALIGN_CHECK = 4'd2, ST_DOCKED = 4'd3,
		ST_GATE = 4'd4, ST_PRESS_CHECK = 4'd5, ST_REFUELING = 4'd6, ST_COMPLETE = 4'd7,
		ST_ABORT = 4'd8, ST_SAFE = 4'd9, ST_FAULT = 4'd10
	} seq_t;

	typedef enum logic [1:0] {
		CTL_IDLE, CTL_EXEC, CTL_DUMP, CTL_TELEM
	} ctl_t;

	localparam logic [4:0] OP_PING = 5'd0, OP_STATUS = 5'd1, OP_LOG = 5'd2,
		OP_RESET = 5'd3, OP_SET_ALIGN = 5'd4, OP_SET_PRESS = 5'd5, OP_ABORT = 5'd6,
		OP_FAULT = 5'd7, OP_APPROACH = 5'd8, OP_CHECK_ALIGN = 5'd9, OP_LOCK = 5'd10,
		OP_GATE = 5'd11, OP_CHECK_PRESS = 5'd12, OP_START = 5'd13, OP_STOP = 5'd14,
		OP_TICK = 5'd15, OP_EMPTY = 5'd16;

	localparam logic [1:0] CFG_ALIGN_MIN = 2'd0, CFG_PRESS_LOW = 2'd1,
		CFG_PRESS_HIGH = 2'd2, CFG_TICKS = 2'd3;

	localparam logic [4:0] LOG_BOOT = 5'd0, LOG_RESET = 5'd1, LOG_APPROACH = 5'd2,
		LOG_ALIGN_OK = 5'd3, LOG_DOCKED = 5'd4, LOG_GATE = 5'd5, LOG_PRESS_OK = 5'd6,
		LOG_REFUEL = 5'd7, LOG_COMPLETE = 5'd8, LOG_STOP = 5'd9, LOG_ABORT = 5'd10,
		LOG_FAULT = 5'd20;

	localparam logic [2:0] CAUSE_NONE = 3'd0, CAUSE_ALIGN = 3'd1, CAUSE_PRESS = 3'd2,
		CAUSE_SUPER = 3'd3, CAUSE_OPER = 3'd4, CAUSE_MANUAL = 3'd5, CAUSE_ALIGN_RANGE = 3'd6;

	localparam logic [1:0] ACT_NONE = 2'd0, ACT_COMPLETE = 2'd1, ACT_ALIGN = 2'd2,
		ACT_PRESS = 2'd3;

	localparam logic [4:0] R_NONE = 5'd0, R_ABORT = 5'd1, R_FAULT = 5'd2, R_EMPTY = 5'd3,
		R_PING = 5'd4, R_RESET = 5'd5, R_ALIGN_NV = 5'd6, R_ALIGN_OOR = 5'd7,
		R_ALIGN_SET = 5'd8, R_PRESS_NV = 5'd9, R_PRESS_OOR = 5'd10, R_PRESS_SET = 5'd11,
		R_LOCKED = 5'd12, R_APPROACH = 5'd13, R_ACHK_NEED = 5'd14, R_ALIGN_OK = 5'd15,
		R_DOCK_NEED = 5'd16, R_DOCKED = 5'd17, R_GATE_NEED = 5'd18, R_GATE = 5'd19,
		R_PCHK_NEED = 5'd20, R_PRESS_OK = 5'd21, R_START_NEED = 5'd22,
		R_START_NODOCK = 5'd23, R_START_NOGATE = 5'd24, R_STARTED = 5'd25,
		R_NOT_REFUEL = 5'd26, R_STOPPED = 5'd27, R_INVALID = 5'd28;

	// controller to datapath
	typedef struct packed {
		logic exec;
		logic dump_start;
		logic dump_next;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic is_log;
		logic dump_done;
	} dp_sts_t;
endpackage
`default_nettype wire

/* sv/refuel_interlock_sequencer.sv */
// Top level: refuel interlock sequencer.
// channel | signals                          | accepted when
// in      | in_valid/in_ready op,has_value,value | in_valid & in_ready
// out     | out_valid/out_ready, 12 fields   | out_valid & out_ready
// cfg     | cfg_we, cfg_index, cfg_data      | cfg_we
// An item is taken in the idle state, evaluated in the exec state, then yields one
// result per log entry (log dump only, up to 12) and one telemetry result.
// The log takes up to two writes per item: one at the end of the evaluate cycle
// and one in the cycle after it. Reset clears all control state; ready waits while
// results are stalled.
`default_nettype none
module refuel_interlock_sequencer
	import ris_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [4:0]  op,
	input  wire logic        has_value,
	input  wire logic signed [10:0] value,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [4:0]       response,
	output logic [1:0]       auto_action,
	output logic [3:0]       ctrl_state,
	output logic [6:0]       alignment_out,
	output logic [6:0]       pressure_out,
	output logic [6:0]       fuel_out,
	output logic             dock_out,
	output logic             gate_out,
	output logic [2:0]       cause_out,
	output logic             is_log_entry,
	output logic [4:0]       log_code,
	output logic             last
);
	dp_cmd_t cmd;
	dp_sts_t sts;

	ris_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_ready, .out_valid, .out_ready, .last,
		.cmd, .sts
	);

	ris_dp u_dp (
		.clk, .arst_n, .cfg_we, .cfg_index, .cfg_data,
		.in_take(in_valid && in_ready), .op, .has_value, .value, .cmd, .sts,
		.response, .auto_action, .ctrl_state, .alignment_out, .pressure_out,
		.fuel_out, .dock_out, .gate_out, .cause_out, .is_log_entry, .log_code
	);
endmodule
`default_nettype wire

/* sv/ris_ctrl.sv */
// Controller: request handshake and sequencing of log dump and telemetry.
`default_nettype none
module ris_ctrl
	import ris_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  wire logic out_ready,
	output logic      last,
	output dp_cmd_t   cmd,
	input  dp_sts_t   sts
);
	ctl_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= CTL_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		in_ready = 1'b0;
		out_valid = 1'b0;
		last = 1'b0;
		cmd = '0;
		unique case (state_q)
			CTL_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) state_d = CTL_EXEC;
			end
			CTL_EXEC: begin
				// evaluate first so a safety abort is logged ahead of the dump
				cmd.exec = 1'b1;
				if (sts.is_log) begin
					cmd.dump_start = 1'b1;
					state_d = CTL_DUMP;
				end else begin
					state_d = CTL_TELEM;
				end
			end
			CTL_DUMP: begin
				out_valid = 1'b1;
				if (out_ready) begin
					cmd.dump_next = 1'b1;
					if (sts.dump_done) state_d = CTL_TELEM;
				end
			end
			CTL_TELEM: begin
				out_valid = 1'b1;
				last = 1'b1;
				if (out_ready) state_d = CTL_IDLE;
			end
			default: state_d = CTL_IDLE;
		endcase
	end
endmodule
`default_nettype wire

/* sv/ris_dp.sv */
// Datapath: sequence state, levels, rolling log and result fields.
`default_nettype none
module ris_dp
	import ris_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_data,
	input  wire logic        in_take,
	input  wire logic [4:0]  op,
	input  wire logic        has_value,
	input  wire logic signed [10:0] value,
	input  dp_cmd_t          cmd,
	output dp_sts_t          sts,
	output logic [4:0]       response,
	output logic [1:0]       auto_action,
	output logic [3:0]       ctrl_state,
	output logic [6:0]       alignment_out,
	output logic [6:0]       pressure_out,
	output logic [6:0]       fuel_out,
	output logic             dock_out,
	output logic             gate_out,
	output logic [2:0]       cause_out,
	output logic             is_log_entry,
	output logic [4:0]       log_code
);
	logic [6:0] align_min_q, press_low_q, press_high_q;
	logic [15:0] ticks_q;
	logic [4:0] op_q;
	logic hv_q;
	logic signed [10:0] val_q;
	seq_t seq_q;
	logic [6:0] align_q, press_q, fuel_q;
	logic dock_q, gate_q;
	logic [2:0] cause_q;
	logic [15:0] tick_q;
	logic [4:0] log_mem_q [LogDepth];
	logic [LogCw-1:0] fill_q;
	logic [LogAw-1:0] head_q;
	logic [LogCw-1:0] dump_i_q;
	logic [4:0] resp_q;
	logic [1:0] act_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			align_min_q <= 7'd60;
			press_low_q <= 7'd20;
			press_high_q <= 7'd80;
			ticks_q <= 16'd7;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_ALIGN_MIN:  align_min_q <= cfg_data[6:0];
				CFG_PRESS_LOW:  press_low_q <= cfg_data[6:0];
				CFG_PRESS_HIGH: press_high_q <= cfg_data[6:0];
				CFG_TICKS:      ticks_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			op_q <= op;
			hv_q <= has_value;
			val_q <= value;
		end
	end

	// next-state evaluation of one request
	seq_t s;
	logic [6:0] al, pr, fu;
	logic dk, gt;
	logic [2:0] ca;
	logic [15:0] tc, tc_inc, tp;
	logic [4:0] rsp;
	logic [1:0] act;
	logic lg_en, al_ok, v_ok;
	logic [4:0] lg_code;

	function automatic logic pbad(input logic [6:0] p, input logic [6:0] lo,
		input logic [6:0] hi);
		return (p < lo) || (p > hi);
	endfunction

	always_comb begin
		s = seq_q; al = align_q; pr = press_q; fu = fuel_q;
		dk = dock_q; gt = gate_q; ca = cause_q; tc = tick_q;
		rsp = R_NONE; act = ACT_NONE; lg_en = 1'b0; lg_code = LOG_BOOT;
		tc_inc = tick_q + 16'd1;
		tp = (ticks_q == 16'd0) ? 16'd1 : ticks_q;
		v_ok = !val_q[10] && (val_q <= 11'sd100);
		al_ok = align_q >= align_min_q;
		// at most one log write before the command: tick completion leaves the
		// refuelling state, so the safety abort cannot follow it
		if (op_q == OP_TICK && seq_q == ST_REFUELING) begin
			tc = tc_inc;
			if (tc_inc >= tp) begin
				tc = '0;
				fu = (fuel_q < 7'd100) ? fuel_q + 7'd5 : fuel_q;
				if (fu >= 7'd100) begin
					fu = 7'd100; gt = 1'b0; s = ST_COMPLETE;
					lg_en = 1'b1; lg_code = LOG_COMPLETE; act = ACT_COMPLETE;
				end
			end
		end
		if (s == ST_REFUELING) begin
			if (align_q < align_min_q) begin
				s = ST_ABORT; gt = 1'b0; ca = CAUSE_ALIGN; act = ACT_ALIGN;
				lg_en = 1'b1; lg_code = LOG_ABORT + 5'(CAUSE_ALIGN);
			end else if (pbad(press_q, press_low_q, press_high_q)) begin
				s = ST_ABORT; gt = 1'b0; ca = CAUSE_PRESS; act = ACT_PRESS;
				lg_en = 1'b1; lg_code = LOG_ABORT + 5'(CAUSE_PRESS);
			end
		end
		// the pre-command abort and a command log may coincide; resolved below
		priority if (op_q == OP_EMPTY) rsp = R_EMPTY;
		else if (op_q == OP_PING) rsp = R_PING;
		else if (op_q == OP_STATUS || op_q == OP_TICK || op_q == OP_LOG) rsp = R_NONE;
		else if (op_q == OP_RESET) begin
			s = ST_SAFE; al = 7'd85; pr = 7'd40; fu = '0; dk = 1'b0; gt = 1'b0;
			ca = CAUSE_NONE; tc = '0; rsp = R_RESET;
		end else if (op_q == OP_SET_ALIGN || op_q == OP_SET_PRESS) begin
			if (!hv_q) rsp = (op_q == OP_SET_ALIGN) ? R_ALIGN_NV : R_PRESS_NV;
			else if (!v_ok) rsp = (op_q == OP_SET_ALIGN) ? R_ALIGN_OOR : R_PRESS_OOR;
			else if (op_q == OP_SET_ALIGN) begin al = val_q[6:0]; rsp = R_ALIGN_SET; end
			else begin pr = val_q[6:0]; rsp = R_PRESS_SET; end
		end else if (op_q == OP_ABORT) begin
			s = ST_ABORT; gt = 1'b0; ca = hv_q ? CAUSE_OPER : CAUSE_SUPER; rsp = R_ABORT;
		end else if (op_q == OP_FAULT) begin
			s = ST_FAULT; gt = 1'b0; ca = CAUSE_MANUAL; rsp = R_FAULT;
		end else if (s == ST_ABORT || s == ST_FAULT) rsp = R_LOCKED;
		else if (op_q == OP_APPROACH) begin
			if (s != ST_IDLE && s != ST_SAFE) rsp = R_INVALID;
			else begin s = ST_APPROACH; rsp = R_APPROACH; end
		end else if (op_q == OP_CHECK_ALIGN) begin
			if (s != ST_APPROACH) rsp = R_ACHK_NEED;
			else if (!al_ok) begin
				s = ST_FAULT; gt = 1'b0; ca = CAUSE_ALIGN_RANGE; rsp = R_FAULT;
			end else begin s = ST_ALIGN_CHECK; rsp = R_ALIGN_OK; end
		end else if (op_q == OP_LOCK) begin
			if (s != ST_ALIGN_CHECK) rsp = R_DOCK_NEED;
			else if (!al_ok) begin
				s = ST_FAULT; gt = 1'b0; ca = CAUSE_ALIGN_RANGE; rsp = R_FAULT;
			end else begin dk = 1'b1; s = ST_DOCKED; rsp = R_DOCKED; end
		end else if (op_q == OP_GATE) begin
			if (s != ST_DOCKED) rsp = R_GATE_NEED;
			else begin gt = 1'b1; s = ST_GATE; rsp = R_GATE; end
		end else if (op_q == OP_CHECK_PRESS) begin
			if (s != ST_GATE) rsp = R_PCHK_NEED;
			else if (pbad(press_q, press_low_q, press_high_q)) begin
				s = ST_FAULT; gt = 1'b0; ca = CAUSE_PRESS; rsp = R_FAULT;
			end else begin s = ST_PRESS_CHECK; rsp = R_PRESS_OK; end
		end else if (op_q == OP_START) begin
			if (s != ST_PRESS_CHECK) rsp = R_START_NEED;
			else if (!dk) rsp = R_START_NODOCK;
			else if (!gt) rsp = R_START_NOGATE;
			else if (!al_ok) begin
				s = ST_FAULT; gt = 1'b0; ca = CAUSE_ALIGN_RANGE; rsp = R_FAULT;
			end else begin s = ST_REFUELING; fu = '0; tc = '0; rsp = R_STARTED; end
		end else if (op_q == OP_STOP) begin
			if (s != ST_REFUELING) rsp = R_NOT_REFUEL;
			else begin s = ST_SAFE; gt = 1'b0; rsp = R_STOPPED; end
		end else rsp = R_INVALID;
	end

	// Command log code; a second log write can follow the pre-command one
	logic cmd_lg;
	logic [4:0] cmd_code;
	always_comb begin
		cmd_lg = 1'b1;
		cmd_code = LOG_BOOT;
		unique case (rsp)
			R_RESET:   cmd_code = LOG_RESET;
			R_ABORT:   cmd_code = LOG_ABORT + 5'(ca);
			R_FAULT:   cmd_code = LOG_FAULT + 5'(ca);
			R_APPROACH: cmd_code = LOG_APPROACH;
			R_ALIGN_OK: cmd_code = LOG_ALIGN_OK;
			R_DOCKED:  cmd_code = LOG_DOCKED;
			R_GATE:    cmd_code = LOG_GATE;
			R_PRESS_OK: cmd_code = LOG_PRESS_OK;
			R_STARTED: cmd_code = LOG_REFUEL;
			R_STOPPED: cmd_code = LOG_STOP;
			default:   cmd_lg = 1'b0;
		endcase
	end

	// post-command safety check: set align, set pressure or start can trip it here
	logic post_ab;
	logic [2:0] post_ca;
	always_comb begin
		post_ab = 1'b0; post_ca = CAUSE_ALIGN;
		if (s == ST_REFUELING) begin
			if (al < align_min_q) post_ab = 1'b1;
			else if (pbad(pr, press_low_q, press_high_q)) begin
				post_ab = 1'b1; post_ca = CAUSE_PRESS;
			end
		end
	end

	// the evaluate cycle writes the first log code; a second one is queued for the next cycle
	logic [2:0] pca_q;
	logic pab_q;
	logic [LogAw-1:0] wr_ptr, rd_ptr;
	logic [LogCw:0] head_sum, rd_sum;
	logic wr_en;
	logic [4:0] wr_code;

	always_comb begin
		head_sum = (LogCw+1)'(head_q) + (LogCw+1)'(fill_q);
		if (head_sum >= (LogCw+1)'(LogDepth)) head_sum = head_sum - (LogCw+1)'(LogDepth);
		rd_sum = (LogCw+1)'(head_q) + (LogCw+1)'(dump_i_q);
		if (rd_sum >= (LogCw+1)'(LogDepth)) rd_sum = rd_sum - (LogCw+1)'(LogDepth);
		wr_ptr = (fill_q < LogCw'(LogDepth)) ? head_sum[LogAw-1:0] : head_q;
		rd_ptr = rd_sum[LogAw-1:0];
	end

	logic pend_q;
	logic [4:0] pend_code_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q <= ST_IDLE; align_q <= 7'd85; press_q <= 7'd40; fuel_q <= '0;
			dock_q <= 1'b0; gate_q <= 1'b0; cause_q <= CAUSE_NONE; tick_q <= '0;
			fill_q <= LogCw'(1); head_q <= '0; dump_i_q <= '0;
			pend_q <= 1'b0; pend_code_q <= LOG_BOOT; pab_q <= 1'b0; pca_q <= CAUSE_NONE;
			resp_q <= R_NONE; act_q <= ACT_NONE;
		end else begin
			if (cmd.dump_start) dump_i_q <= '0;
			else if (cmd.dump_next) dump_i_q <= dump_i_q + LogCw'(1);
			if (cmd.exec) begin
				seq_q <= post_ab ? ST_ABORT : s;
				align_q <= al; press_q <= pr; fuel_q <= fu; dock_q <= dk;
				gate_q <= post_ab ? 1'b0 : gt;
				cause_q <= post_ab ? post_ca : ca;
				tick_q <= tc;
				resp_q <= rsp;
				act_q <= post_ab ? (post_ca == CAUSE_ALIGN ? ACT_ALIGN : ACT_PRESS) : act;
				// queue writes: pre-command log, command log, post abort
				pend_q <= (lg_en && cmd_lg) || ((lg_en || cmd_lg) && post_ab);
				pend_code_q <= post_ab ? LOG_ABORT + 5'(post_ca) : cmd_code;
				pab_q <= (lg_en && cmd_lg) && post_ab;
				pca_q <= post_ca;
			end else if (pend_q) begin
				pend_q <= pab_q;
				pend_code_q <= LOG_ABORT + 5'(pca_q);
				pab_q <= 1'b0;
			end
			if (wr_en) begin
				if (fill_q < LogCw'(LogDepth)) fill_q <= fill_q + LogCw'(1);
				else head_q <= (head_q == LogAw'(LogDepth - 1)) ? '0 : head_q + LogAw'(1);
			end
		end
	end

	always_comb begin
		wr_en = 1'b0; wr_code = pend_code_q;
		if (cmd.exec) begin
			wr_en = lg_en || cmd_lg || post_ab;
			wr_code = lg_en ? lg_code : (cmd_lg ? cmd_code : LOG_ABORT + 5'(post_ca));
		end else if (pend_q) wr_en = 1'b1;
	end

	always_ff @(posedge clk) begin
		if (wr_en) log_mem_q[wr_ptr] <= wr_code;
	end

	// entry 0 holds the boot code until it is first overwritten
	logic seen_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) seen_q <= 1'b0;
		else if (wr_en && wr_ptr == '0) seen_q <= 1'b1;
	end

	logic [4:0] rd_code;
	assign rd_code = log_mem_q[rd_ptr];

	logic dumping_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) dumping_q <= 1'b0;
		else if (cmd.dump_start) dumping_q <= 1'b1;
		else if (cmd.dump_next && sts.dump_done) dumping_q <= 1'b0;
	end

	assign sts.is_log = (op_q == OP_LOG);
	assign sts.dump_done = (dump_i_q + LogCw'(1) >= fill_q);

	assign is_log_entry = dumping_q;
	assign log_code     = dumping_q ? ((rd_ptr == '0 && !seen_q) ? LOG_BOOT : rd_code) : '0;
	assign response     = dumping_q ? '0 : resp_q;
	assign auto_action  = dumping_q ? '0 : act_q;
	assign ctrl_state   = dumping_q ? '0 : seq_q;
	assign alignment_out = dumping_q ? '0 : align_q;
	assign pressure_out = dumping_q ? '0 : press_q;
	assign fuel_out     = dumping_q ? '0 : fuel_q;
	assign dock_out     = dumping_q ? '0 : dock_q;
	assign gate_out     = dumping_q ? '0 : gate_q;
	assign cause_out    = dumping_q ? '0 : cause_q;
endmodule
`default_nettype wire

/* sv/ris_checker.sv */
// Checker: port-level properties of the refuel interlock sequencer.
`default_nettype none
module ris_checker
	import ris_pkg::*;
(
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_ready,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic       last,
	input wire logic       is_log_entry,
	input wire logic [3:0] ctrl_state,
	input wire logic [4:0] response
);
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid)) else $error("ready during results");
	a_last_telem: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last |-> !is_log_entry) else $error("last on log entry");
	a_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready) else $error("ready right after request");
	a_ready_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && last |=> in_ready) else $error("no ready after last");
	a_fault_resp: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last && response == R_FAULT |-> ctrl_state == ST_FAULT)
		else $error("fault response without fault state");
endmodule

bind refuel_interlock_sequencer ris_checker u_ris_checker (
	.clk, .arst_n, .in_valid, .in_ready, .out_valid, .out_ready, .last,
	.is_log_entry, .ctrl_state, .response
);
`default_nettype wire

/* test/tb_top.sv */
// Testbench for the refuel interlock sequencer: predicted results checked field by field.
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
	import ris_pkg::*;

	localparam logic [4:0] OP_UNKNOWN = 5'd17;
	localparam logic [4:0] OP_TOP = 5'd31;
	localparam int CycleLimit = 600000;
	localparam int SettleCycles = 24;

	typedef struct packed {
		logic [4:0] response;
		logic [1:0] auto_action;
		logic [3:0] ctrl_state;
		logic [6:0] alignment;
		logic [6:0] pressure;
		logic [6:0] fuel;
		logic       dock;
		logic       gate;
		logic [2:0] cause;
		logic       is_log;
		logic [4:0] code;
		logic       last;
	} telem_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = CFG_ALIGN_MIN;
	logic [15:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [4:0] op = OP_PING;
	logic has_value = 1'b0;
	logic signed [10:0] value = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [4:0] response;
	logic [1:0] auto_action;
	logic [3:0] ctrl_state;
	logic [6:0] alignment_out, pressure_out, fuel_out;
	logic dock_out, gate_out;
	logic [2:0] cause_out;
	logic is_log_entry;
	logic [4:0] log_code;
	logic last;

	refuel_interlock_sequencer uut (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// predictor state
	int align_min_r, press_low_r, press_high_r, ticks_step_r;
	seq_t seq_q;
	int align_q, press_q, fuel_q, cause_q, tick_q;
	bit dock_q, gate_q;
	int events_q[LogDepth];
	int event_fill, event_head;

	telem_t pending_results[$];
	int failures = 0;
	int sent = 0;
	bit idle_en = 1'b1;
	bit hold_req = 1'b0;
	int cycles = 0;

	task automatic log_event(input int code);
		if (event_fill < LogDepth) begin
			events_q[(event_head + event_fill) % LogDepth] = code & 31;
			event_fill++;
		end else begin
			events_q[event_head] = code & 31;
			event_head = (event_head + 1) % LogDepth;
		end
	endtask

	task automatic latch_abort(input int cause);
		seq_q = ST_ABORT;
		gate_q = 1'b0;
		cause_q = cause;
		log_event(LOG_ABORT + cause);
	endtask

	task automatic latch_fault(input int cause);
		seq_q = ST_FAULT;
		gate_q = 1'b0;
		cause_q = cause;
		log_event(LOG_FAULT + cause);
	endtask

	function automatic bit press_out_of_band();
		return press_q < press_low_r || press_q > press_high_r;
	endfunction

	task automatic guard_refuel(inout int act);
		if (seq_q == ST_REFUELING) begin
			if (align_q < align_min_r) begin
				latch_abort(CAUSE_ALIGN);
				act = ACT_ALIGN;
			end else if (press_out_of_band()) begin
				latch_abort(CAUSE_PRESS);
				act = ACT_PRESS;
			end
		end
	endtask

	task automatic reset_model();
		align_min_r = 60; press_low_r = 20; press_high_r = 80; ticks_step_r = 7;
		seq_q = ST_IDLE; align_q = 85; press_q = 40; fuel_q = 0;
		dock_q = 0; gate_q = 0; cause_q = CAUSE_NONE; tick_q = 0;
		events_q[0] = LOG_BOOT; event_fill = 1; event_head = 0;
	endtask

	// expected results of one accepted request
	task automatic predict_request(input logic [4:0] o, input logic hv,
		input logic signed [10:0] val);
		int v;
		int resp;
		int act;
		int base;
		telem_t t;
		v = val;
		resp = R_NONE;
		act = ACT_NONE;
		if (o == OP_TICK && seq_q == ST_REFUELING) begin
			tick_q = (tick_q + 1) & 16'hffff;
			if (tick_q >= ticks_step_r) begin
				tick_q = 0;
				if (fuel_q < 100) fuel_q += 5;
				if (fuel_q >= 100) begin
					fuel_q = 100; gate_q = 0; seq_q = ST_COMPLETE;
					log_event(LOG_COMPLETE);
					act = ACT_COMPLETE;
				end
			end
		end
		guard_refuel(act);
		if (o == OP_EMPTY) resp = R_EMPTY;
		else if (o == OP_PING) resp = R_PING;
		else if (o == OP_STATUS || o == OP_TICK) resp = R_NONE;
		else if (o == OP_LOG) begin
			for (int i = 0; i < event_fill; i++) begin
				t = '0;
				t.is_log = 1'b1;
				t.code = 5'(events_q[(event_head + i) % LogDepth]);
				pending_results.push_back(t);
			end
		end else if (o == OP_RESET) begin
			seq_q = ST_SAFE; align_q = 85; press_q = 40; fuel_q = 0;
			dock_q = 0; gate_q = 0; cause_q = CAUSE_NONE; tick_q = 0;
			log_event(LOG_RESET);
			resp = R_RESET;
		end else if (o == OP_SET_ALIGN || o == OP_SET_PRESS) begin
			base = (o == OP_SET_ALIGN) ? R_ALIGN_NV : R_PRESS_NV;
			if (!hv) resp = base;
			else if (v < 0 || v > 100) resp = base + 1;
			else begin
				if (o == OP_SET_ALIGN) align_q = v;
				else press_q = v;
				resp = base + 2;
			end
		end else if (o == OP_ABORT) begin
			latch_abort(hv ? CAUSE_OPER : CAUSE_SUPER);
			resp = R_ABORT;
		end else if (o == OP_FAULT) begin
			latch_fault(CAUSE_MANUAL);
			resp = R_FAULT;
		end else if (seq_q == ST_ABORT || seq_q == ST_FAULT) resp = R_LOCKED;
		else if (o == OP_APPROACH) begin
			if (seq_q != ST_IDLE && seq_q != ST_SAFE) resp = R_INVALID;
			else begin
				seq_q = ST_APPROACH; log_event(LOG_APPROACH); resp = R_APPROACH;
			end
		end else if (o == OP_CHECK_ALIGN) begin
			if (seq_q != ST_APPROACH) resp = R_ACHK_NEED;
			else begin
				seq_q = ST_ALIGN_CHECK;
				if (align_q < align_min_r) begin
					latch_fault(CAUSE_ALIGN_RANGE); resp = R_FAULT;
				end else begin
					log_event(LOG_ALIGN_OK); resp = R_ALIGN_OK;
				end
			end
		end else if (o == OP_LOCK) begin
			if (seq_q != ST_ALIGN_CHECK) resp = R_DOCK_NEED;
			else if (align_q < align_min_r) begin
				latch_fault(CAUSE_ALIGN_RANGE); resp = R_FAULT;
			end else begin
				dock_q = 1; seq_q = ST_DOCKED; log_event(LOG_DOCKED); resp = R_DOCKED;
			end
		end else if (o == OP_GATE) begin
			if (seq_q != ST_DOCKED) resp = R_GATE_NEED;
			else begin
				gate_q = 1; seq_q = ST_GATE; log_event(LOG_GATE); resp = R_GATE;
			end
		end else if (o == OP_CHECK_PRESS) begin
			if (seq_q != ST_GATE) resp = R_PCHK_NEED;
			else if (press_out_of_band()) begin
				latch_fault(CAUSE_PRESS); resp = R_FAULT;
			end else begin
				seq_q = ST_PRESS_CHECK; log_event(LOG_PRESS_OK); resp = R_PRESS_OK;
			end
		end else if (o == OP_START) begin
			if (seq_q != ST_PRESS_CHECK) resp = R_START_NEED;
			else if (!dock_q) resp = R_START_NODOCK;
			else if (!gate_q) resp = R_START_NOGATE;
			else if (align_q < align_min_r) begin
				latch_fault(CAUSE_ALIGN_RANGE); resp = R_FAULT;
			end else begin
				seq_q = ST_REFUELING; fuel_q = 0; tick_q = 0;
				log_event(LOG_REFUEL); resp = R_STARTED;
			end
		end else if (o == OP_STOP) begin
			if (seq_q != ST_REFUELING) resp = R_NOT_REFUEL;
			else begin
				seq_q = ST_SAFE; gate_q = 0; log_event(LOG_STOP); resp = R_STOPPED;
			end
		end else resp = R_INVALID;
		guard_refuel(act);
		t = '0;
		t.response = 5'(resp); t.auto_action = 2'(act); t.ctrl_state = seq_q;
		t.alignment = 7'(align_q); t.pressure = 7'(press_q); t.fuel = 7'(fuel_q);
		t.dock = dock_q; t.gate = gate_q; t.cause = 3'(cause_q); t.last = 1'b1;
		pending_results.push_back(t);
	endtask

	task automatic send_request(input logic [4:0] o, input logic hv,
		input logic signed [10:0] val);
		if (idle_en && $urandom_range(0, 4) == 0) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 7)) @(negedge clk);
		end
		in_valid = 1'b1;
		op = o;
		has_value = hv;
		value = val;
		do @(posedge clk); while (!in_ready);
		predict_request(o, hv, val);
		sent++;
		@(negedge clk);
	endtask

	// hold until the block is idle
	task automatic drain();
		in_valid = 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
		repeat (SettleCycles) @(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input int data);
		drain();
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = 16'(data);
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			CFG_ALIGN_MIN: align_min_r = data & 127;
			CFG_PRESS_LOW: press_low_r = data & 127;
			CFG_PRESS_HIGH: press_high_r = data & 127;
			default: ticks_step_r = data & 16'hffff;
		endcase
	endtask

	task automatic dock_and_fuel(input int ticks);
		send_request(OP_APPROACH, 0, 0);
		send_request(OP_CHECK_ALIGN, 0, 0);
		send_request(OP_LOCK, 0, 0);
		send_request(OP_GATE, 0, 0);
		send_request(OP_CHECK_PRESS, 0, 0);
		send_request(OP_START, 0, 0);
		repeat (ticks) send_request(OP_TICK, 0, 0);
	endtask

	task automatic test_directed();
		send_request(OP_LOG, 0, 0);
		send_request(OP_PING, 0, 0);
		send_request(OP_STATUS, 1, 11'sd1023);
		send_request(OP_EMPTY, 0, 0);
		send_request(OP_UNKNOWN, 0, 0);
		send_request(OP_TOP, 1, -11'sd1024);
		send_request(OP_SET_ALIGN, 0, 50);
		send_request(OP_SET_ALIGN, 1, -1);
		send_request(OP_SET_PRESS, 1, 101);
		send_request(OP_SET_PRESS, 1, 0);
		send_request(OP_SET_PRESS, 1, 100);
		send_request(OP_SET_ALIGN, 1, 100);
		send_request(OP_CHECK_PRESS, 0, 0);
		send_request(OP_ABORT, 0, 0);
		send_request(OP_APPROACH, 0, 0);
		send_request(OP_TICK, 0, 0);
		send_request(OP_ABORT, 1, 0);
		send_request(OP_RESET, 0, 0);
		send_request(OP_FAULT, 0, 0);
		send_request(OP_STOP, 0, 0);
		send_request(OP_RESET, 0, 0);
		send_request(OP_SET_ALIGN, 1, 0);
		send_request(OP_APPROACH, 0, 0);
		send_request(OP_CHECK_ALIGN, 0, 0);
		send_request(OP_LOG, 0, 0);
	endtask

	// full refuel to completion and a stop mid-fuel
	task automatic test_refuel_paths();
		write_reg(CFG_TICKS, 1);
		send_request(OP_RESET, 0, 0);
		dock_and_fuel(21);
		send_request(OP_RESET, 0, 0);
		dock_and_fuel(3);
		send_request(OP_STOP, 0, 0);
		send_request(OP_LOG, 0, 0);
	endtask

	task automatic test_backpressure();
		drain();
		hold_req = 1'b1;
		repeat (16) send_request(OP_LOG, 0, 0);
		drain();
	endtask

	task automatic random_request();
		logic [4:0] o;
		o = 5'($urandom_range(0, 31));
		send_request(o, 1'($urandom_range(0, 1)), 11'($urandom));
	endtask

	task automatic random_sequence();
		int n;
		if ($urandom_range(0, 3) != 0) send_request(OP_RESET, 0, 0);
		if ($urandom_range(0, 2) == 0)
			send_request(OP_SET_ALIGN, 1, 11'($urandom_range(40, 100)));
		if ($urandom_range(0, 2) == 0)
			send_request(OP_SET_PRESS, 1, 11'($urandom_range(0, 100)));
		send_request(OP_APPROACH, 0, 0);
		send_request(OP_CHECK_ALIGN, 0, 0);
		send_request(OP_LOCK, 0, 0);
		send_request(OP_GATE, 0, 0);
		send_request(OP_CHECK_PRESS, 0, 0);
		send_request(OP_START, 0, 0);
		n = $urandom_range(0, 28);
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(0, 19))
				0: send_request(OP_SET_ALIGN, 1, 11'($urandom_range(30, 100)));
				1: send_request(OP_SET_PRESS, 1, 11'($urandom_range(0, 100)));
				2: send_request(OP_STATUS, 0, 0);
				3: random_request();
				default: send_request(OP_TICK, 0, 0);
			endcase
		end
		if ($urandom_range(0, 3) == 0) send_request(OP_STOP, 0, 0);
		if ($urandom_range(0, 4) == 0) send_request(OP_LOG, 0, 0);
	endtask

	task automatic test_random(input int target);
		while (sent < target) begin
			if ($urandom_range(0, 4) == 0) random_request();
			else random_sequence();
		end
	endtask

	task automatic test_settings();
		write_reg(CFG_TICKS, 2);
		write_reg(CFG_ALIGN_MIN, 0);
		write_reg(CFG_PRESS_LOW, 0);
		write_reg(CFG_PRESS_HIGH, 100);
		test_random(200);
		write_reg(CFG_ALIGN_MIN, 100);
		write_reg(CFG_PRESS_LOW, 50);
		write_reg(CFG_PRESS_HIGH, 30);
		write_reg(CFG_TICKS, 65535);
		test_random(240);
		write_reg(CFG_ALIGN_MIN, 70);
		write_reg(CFG_PRESS_LOW, 30);
		write_reg(CFG_PRESS_HIGH, 70);
		write_reg(CFG_TICKS, 0);
		test_random(320);
		write_reg(CFG_ALIGN_MIN, 60);
		write_reg(CFG_PRESS_LOW, 20);
		write_reg(CFG_PRESS_HIGH, 80);
		write_reg(CFG_TICKS, 3);
		test_random(390);
		idle_en = 1'b0;
		test_random(450);
	endtask

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("Verification failed");
			$finish;
		end
	end

	// receiver: random stalls, one long hold-off on request
	initial begin
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_ready = 1'b0;
				repeat (300) @(negedge clk);
				hold_req = 1'b0;
			end else if (idle_en && $urandom_range(0, 5) == 0) begin
				out_ready = 1'b0;
				repeat ($urandom_range(1, 7)) @(negedge clk);
			end
			out_ready = 1'b1;
		end
	end

	task automatic check_field(input string name, input int exp, input int act);
		if (exp != act) begin
			$error("%s: expected %0d, got %0d", name, exp, act);
			failures++;
		end
	endtask

	always @(posedge clk) begin
		telem_t e;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$error("result with no request pending");
				failures++;
			end else begin
				e = pending_results.pop_front();
				check_field("response", e.response, response);
				check_field("auto_action", e.auto_action, auto_action);
				check_field("ctrl_state", e.ctrl_state, ctrl_state);
				check_field("alignment_out", e.alignment, alignment_out);
				check_field("pressure_out", e.pressure, pressure_out);
				check_field("fuel_out", e.fuel, fuel_out);
				check_field("dock_out", e.dock, dock_out);
				check_field("gate_out", e.gate, gate_out);
				check_field("cause_out", e.cause, cause_out);
				check_field("is_log_entry", e.is_log, is_log_entry);
				check_field("log_code", e.code, log_code);
				check_field("last", e.last, last);
			end
		end
	end

	initial begin
		reset_model();
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_refuel_paths();
		test_backpressure();
		test_settings();
		drain();
		if (failures == 0 && pending_results.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end
endmodule
`default_nettype wire
